/* design/psc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// shared types, codes and character classes for the program syntax checker
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  typedef enum logic [1:0] {
    LBL_NONE,
    LBL_MEM,
    LBL_PROC
  } lbl_kind_t;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_BAD_INSTR  = 4'd1;
  localparam logic [3:0] ST_BAD_MEM    = 4'd2;
  localparam logic [3:0] ST_BAD_PROC   = 4'd3;
  localparam logic [3:0] ST_UNOPENED   = 4'd4;
  localparam logic [3:0] ST_MISMATCH   = 4'd5;
  localparam logic [3:0] ST_UNCLOSED   = 4'd6;
  localparam logic [3:0] ST_NESTED     = 4'd7;
  localparam logic [3:0] ST_OVERFLOW   = 4'd8;

  // opener kinds held in the stack cells
  localparam logic [1:0] KIND_BRACE    = 2'd0;
  localparam logic [1:0] KIND_BRACKET  = 2'd1;
  localparam logic [1:0] KIND_PROC     = 2'd2;
  localparam logic [1:0] KIND_ZERO     = 2'd3;

  localparam logic [7:0] CH_QMARK      = 8'h3F;
  localparam logic [7:0] CH_SEMI       = 8'h3B;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  offending_char;
    logic [7:0]  expected_opener;
    logic [15:0] position;
  } verdict_t;

  function automatic logic [7:0] opener_char(input logic [1:0] kind);
    logic [7:0] c;
    case (kind)
      KIND_BRACE:   c = "{";
      KIND_BRACKET: c = "[";
      KIND_PROC:    c = "?";
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_instr(input logic [7:0] b);
    logic r;
    case (b)
      8'h00, ">", "<", "+", "-", ".", ",", "[", "]", "{", "}",
      "?", ";", "!", ":", "%", "@", "&", "=", "$": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_mem_sym(input logic [7:0] b);
    logic r;
    case (b)
      "%", "@", "&", "=", "$": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_proc_sym(input logic [7:0] b);
    logic r;
    case (b)
      "?", "!": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return (b == 8'h00) || ((b >= "a") && (b <= "z"));
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return (b == 8'h00) || ((b >= "A") && (b <= "Z"));
  endfunction

endpackage

/* design/program_syntax_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program_syntax_checker
// symbol, bracket and procedure checks over a byte stream, one verdict per end
// ----------------------------------------------------------------------------
// usage:
//   input words carry one program byte each (in_tuser = 0) or an end mark
//   (in_tuser = 1). bytes give no output. an end word yields one verdict word
//   on the output channel and clears all checker state for the next program.
//   one input word is taken per clock while in_tready is high; each byte moves
//   the chain of stack cells by at most a single push or pop step.
//   the verdict is registered, in the skid slot if the output register is busy.
//   the output has a register and one skid slot; bytes keep flowing while a
//   verdict waits, and in_tready drops only once a second verdict fills the
//   skid slot, until the receiver takes a word.
//   reset clears counters, flags and the stack pointer; stack cells hold no
//   reset value and are read only after a push.
// ----------------------------------------------------------------------------
module program_syntax_checker #(
  parameter int STACK_DEPTH        = 256,
  parameter int MAX_PROGRAM_LENGTH = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] program_byte
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [3:0] status, [11:4] offending_char,
                                  // [19:12] expected_opener, [35:20] position
);
  import psc_pkg::*;

  localparam int          SPW     = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PROGRAM_LENGTH);

  logic [15:0]    byte_count_r, byte_count_nxt;
  lbl_kind_t      pend_r, pend_nxt;
  logic [15:0]    pend_idx_r, pend_idx_nxt;
  logic           sym_v_r, sym_v_nxt;
  logic [3:0]     sym_st_r, sym_st_nxt;
  logic [7:0]     sym_ch_r, sym_ch_nxt;
  logic [15:0]    sym_pos_r, sym_pos_nxt;
  logic           enc_v_r, enc_v_nxt;
  logic [3:0]     enc_st_r, enc_st_nxt;
  logic [7:0]     enc_ch_r, enc_ch_nxt;
  logic [7:0]     enc_op_r, enc_op_nxt;
  logic [15:0]    enc_pos_r, enc_pos_nxt;
  logic           proc_v_r, proc_v_nxt;
  logic [15:0]    proc_pos_r, proc_pos_nxt;
  logic           inside_r, inside_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  verdict_t       out_data_r, out_data_nxt;
  verdict_t       skid_data_r, skid_data_nxt;

  stk_op_t        stk_op;
  logic [1:0]     push_kind;
  logic [1:0]     cell_kind [STACK_DEPTH];
  logic [1:0]     cell_prev [STACK_DEPTH];
  logic [1:0]     cell_next [STACK_DEPTH];
  logic [1:0]     top_kind;

  logic           in_fire, end_fire, byte_fire, out_take;
  logic [7:0]     b;
  logic           is_open, is_close;
  logic [1:0]     open_kind, close_kind;
  verdict_t       verdict;

  // stack cell chain, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_prev[i] = push_kind;
    end else begin : g_mid
      assign cell_prev[i] = cell_kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign cell_next[i] = cell_kind[i];
    end else begin : g_inner
      assign cell_next[i] = cell_kind[i+1];
    end
    psc_cell u_cell (
      .clk       (clk),
      .op        (stk_op),
      .prev_kind (cell_prev[i]),
      .next_kind (cell_next[i]),
      .kind      (cell_kind[i])
    );
  end

  assign top_kind  = cell_kind[0];
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign end_fire  = in_fire && in_tuser[0];
  assign byte_fire = in_fire && !in_tuser[0] && (byte_count_r < MAX_LEN);
  assign out_take  = out_valid_r && out_tready;
  assign b         = in_tdata;

  always_comb begin
    is_open    = 1'b1;
    open_kind  = KIND_ZERO;
    is_close   = 1'b0;
    close_kind = KIND_BRACE;
    case (b)
      "{":     open_kind = KIND_BRACE;
      "[":     open_kind = KIND_BRACKET;
      "?":     open_kind = KIND_PROC;
      8'h00:   open_kind = KIND_ZERO;
      default: is_open = 1'b0;
    endcase
    case (b)
      "}":     begin is_close = 1'b1; close_kind = KIND_BRACE;   end
      "]":     begin is_close = 1'b1; close_kind = KIND_BRACKET; end
      ";":     begin is_close = 1'b1; close_kind = KIND_PROC;    end
      default: is_close = 1'b0;
    endcase
  end

  // verdict from current state, with trailing label and unclosed opener
  always_comb begin
    verdict = '0;
    if (sym_v_r) begin
      verdict.status         = sym_st_r;
      verdict.offending_char = sym_ch_r;
      verdict.position       = sym_pos_r;
    end else if (pend_r != LBL_NONE) begin
      verdict.status   = (pend_r == LBL_MEM) ? ST_BAD_MEM : ST_BAD_PROC;
      verdict.position = pend_idx_r;
    end else if (enc_v_r) begin
      verdict.status          = enc_st_r;
      verdict.offending_char  = enc_ch_r;
      verdict.expected_opener = enc_op_r;
      verdict.position        = enc_pos_r;
    end else if (sp_r != '0) begin
      verdict.status         = ST_UNCLOSED;
      verdict.offending_char = opener_char(top_kind);
      verdict.position       = byte_count_r;
    end else if (proc_v_r) begin
      verdict.status         = ST_NESTED;
      verdict.offending_char = CH_QMARK;
      verdict.position       = proc_pos_r;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    sym_v_nxt      = sym_v_r;
    sym_st_nxt     = sym_st_r;
    sym_ch_nxt     = sym_ch_r;
    sym_pos_nxt    = sym_pos_r;
    enc_v_nxt      = enc_v_r;
    enc_st_nxt     = enc_st_r;
    enc_ch_nxt     = enc_ch_r;
    enc_op_nxt     = enc_op_r;
    enc_pos_nxt    = enc_pos_r;
    proc_v_nxt     = proc_v_r;
    proc_pos_nxt   = proc_pos_r;
    inside_nxt     = inside_r;
    sp_nxt         = sp_r;
    stk_op         = STK_HOLD;
    push_kind      = open_kind;

    if (byte_fire) begin
      byte_count_nxt = byte_count_r + 16'd1;

      // symbol and label check
      if (!sym_v_r) begin
        case (pend_r)
          LBL_MEM: begin
            if (!is_lower(b)) begin
              sym_v_nxt   = 1'b1;
              sym_st_nxt  = ST_BAD_MEM;
              sym_ch_nxt  = b;
              sym_pos_nxt = pend_idx_r;
            end
            pend_nxt = LBL_NONE;
          end
          LBL_PROC: begin
            if (!is_upper(b)) begin
              sym_v_nxt   = 1'b1;
              sym_st_nxt  = ST_BAD_PROC;
              sym_ch_nxt  = b;
              sym_pos_nxt = pend_idx_r;
            end
            pend_nxt = LBL_NONE;
          end
          default: begin
            if (!is_instr(b)) begin
              sym_v_nxt   = 1'b1;
              sym_st_nxt  = ST_BAD_INSTR;
              sym_ch_nxt  = b;
              sym_pos_nxt = byte_count_r;
            end else if (is_mem_sym(b)) begin
              pend_nxt     = LBL_MEM;
              pend_idx_nxt = byte_count_r;
            end else if (is_proc_sym(b)) begin
              pend_nxt     = LBL_PROC;
              pend_idx_nxt = byte_count_r;
            end
          end
        endcase
      end

      // bracket check
      if (!enc_v_r) begin
        if (is_open) begin
          if (sp_r == SP_FULL) begin
            enc_v_nxt   = 1'b1;
            enc_st_nxt  = ST_OVERFLOW;
            enc_ch_nxt  = b;
            enc_op_nxt  = 8'h00;
            enc_pos_nxt = byte_count_r;
          end else begin
            stk_op = STK_PUSH;
            sp_nxt = sp_r + SPW'(1);
          end
        end else if (is_close) begin
          if (sp_r == '0) begin
            enc_v_nxt   = 1'b1;
            enc_st_nxt  = ST_UNOPENED;
            enc_ch_nxt  = b;
            enc_op_nxt  = 8'h00;
            enc_pos_nxt = byte_count_r;
          end else if (top_kind != close_kind) begin
            enc_v_nxt   = 1'b1;
            enc_st_nxt  = ST_MISMATCH;
            enc_ch_nxt  = b;
            enc_op_nxt  = opener_char(top_kind);
            enc_pos_nxt = byte_count_r;
          end else begin
            stk_op = STK_POP;
            sp_nxt = sp_r - SPW'(1);
          end
        end
      end

      // nested procedure check
      if (!proc_v_r) begin
        if (b == CH_QMARK) begin
          if (inside_r) begin
            proc_v_nxt   = 1'b1;
            proc_pos_nxt = byte_count_r;
          end else begin
            inside_nxt = 1'b1;
          end
        end else if (b == CH_SEMI) begin
          inside_nxt = 1'b0;
        end
      end
    end else if (end_fire) begin
      byte_count_nxt = '0;
      pend_nxt       = LBL_NONE;
      pend_idx_nxt   = '0;
      sym_v_nxt      = 1'b0;
      enc_v_nxt      = 1'b0;
      proc_v_nxt     = 1'b0;
      inside_nxt     = 1'b0;
      sp_nxt         = '0;
    end
  end

  // output register and skid slot
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (end_fire) begin
      if (!out_valid_r || out_take) begin
        out_data_nxt  = verdict;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = verdict;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      pend_r       <= LBL_NONE;
      pend_idx_r   <= '0;
      sym_v_r      <= 1'b0;
      enc_v_r      <= 1'b0;
      proc_v_r     <= 1'b0;
      inside_r     <= 1'b0;
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      pend_r       <= pend_nxt;
      pend_idx_r   <= pend_idx_nxt;
      sym_v_r      <= sym_v_nxt;
      enc_v_r      <= enc_v_nxt;
      proc_v_r     <= proc_v_nxt;
      inside_r     <= inside_nxt;
      sp_r         <= sp_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_st_r    <= sym_st_nxt;
    sym_ch_r    <= sym_ch_nxt;
    sym_pos_r   <= sym_pos_nxt;
    enc_st_r    <= enc_st_nxt;
    enc_ch_r    <= enc_ch_nxt;
    enc_op_r    <= enc_op_nxt;
    enc_pos_r   <= enc_pos_nxt;
    proc_pos_r  <= proc_pos_nxt;
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r.position, out_data_r.expected_opener,
                       out_data_r.offending_char, out_data_r.status};

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_FULL)
    else $error("stack pointer beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> (sp_r == '0) && (byte_count_r == '0) && !sym_v_r && !enc_v_r)
    else $error("state not cleared after end word");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot filled while output register empty");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status <= ST_OVERFLOW))
    else $error("verdict status out of range");

  a_end_lands: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> out_valid_r)
    else $error("end word produced no verdict");

endmodule

/* design/psc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_cell
// one slot of the shifting bracket stack, takes from its upper or lower neighbor
// ----------------------------------------------------------------------------
module psc_cell (
  input  logic             clk,
  input  psc_pkg::stk_op_t op,
  input  logic [1:0]       prev_kind,
  input  logic [1:0]       next_kind,
  output logic [1:0]       kind
);
  import psc_pkg::*;

  logic [1:0] kind_r;
  logic [1:0] kind_nxt;

  always_comb begin
    case (op)
      STK_PUSH: kind_nxt = prev_kind;
      STK_POP:  kind_nxt = next_kind;
      default:  kind_nxt = kind_r;
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind = kind_r;

endmodule
